[rtl/dfr_pkg.sv]
// Shared types, constants and the byte-wide CRC-16 update for the frame deframer.
package dfr_pkg;

    localparam int          SYNC_COUNT_DEF = 3;
    localparam int          RUN_W          = 2;
    localparam logic [7:0]  SYNC_BYTE_RST  = 8'd62;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'h1021;

    // Parse phase, one-hot
    typedef enum logic [7:0] {
        PH_HUNT    = 8'b0000_0001,
        PH_TOPIC   = 8'b0000_0010,
        PH_SEQ     = 8'b0000_0100,
        PH_LEN_HI  = 8'b0000_1000,
        PH_LEN_LO  = 8'b0001_0000,
        PH_CRC_HI  = 8'b0010_0000,
        PH_CRC_LO  = 8'b0100_0000,
        PH_PAYLOAD = 8'b1000_0000
    } phase_t;

    // One result item plus a flag saying whether the byte produced one
    typedef struct packed {
        logic        has_result;
        logic [7:0]  payload_byte;
        logic        byte_valid;
        logic        frame_end;
        logic        crc_ok;
        logic [7:0]  topic;
        logic [15:0] frame_len;
    } result_t;

    // CRC-16/CCITT-FALSE, one byte, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[rtl/dfr_parser.sv]
// Frame parse state machine: sync hunt, header capture, payload CRC and result build.
module dfr_parser
    import dfr_pkg::*;
#(
    parameter int SYNC_COUNT = SYNC_COUNT_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] rx_byte,
    input  logic [7:0] sync_byte,
    output result_t    result
);

    localparam logic [RUN_W:0] SYNC_NEED = (RUN_W + 1)'(SYNC_COUNT);

    phase_t      phase_reg, phase_next;
    logic [RUN_W-1:0] run_reg, run_next;
    logic [7:0]  topic_reg, topic_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] left_reg, left_next;
    logic [15:0] exp_crc_reg, exp_crc_next;
    logic [15:0] crc_reg, crc_next;

    logic [15:0] crc_upd;
    logic [15:0] left_dec;
    logic [15:0] exp_full;
    logic [RUN_W:0] run_inc;

    assign crc_upd  = crc16_byte(crc_reg, rx_byte);
    assign left_dec = left_reg - 16'd1;
    assign exp_full = {exp_crc_reg[15:8], rx_byte};
    assign run_inc  = {1'b0, run_reg} + {{RUN_W{1'b0}}, 1'b1};

    // Decode the current byte against the parse phase
    always_comb begin
        phase_next   = phase_reg;
        run_next     = run_reg;
        topic_next   = topic_reg;
        length_next  = length_reg;
        left_next    = left_reg;
        exp_crc_next = exp_crc_reg;
        crc_next     = crc_reg;

        result           = '0;
        result.topic     = topic_reg;
        result.frame_len = length_reg;

        case (phase_reg)
            PH_HUNT: begin
                if (rx_byte == sync_byte) begin
                    if (run_inc >= SYNC_NEED) begin
                        run_next   = '0;
                        phase_next = PH_TOPIC;
                    end else begin
                        run_next = run_inc[RUN_W-1:0];
                    end
                end else begin
                    run_next = '0;
                end
            end
            PH_TOPIC: begin
                topic_next = rx_byte;
                phase_next = PH_SEQ;
            end
            PH_SEQ: begin
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                length_next = {rx_byte, 8'h00};
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                length_next = {length_reg[15:8], rx_byte};
                phase_next  = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                exp_crc_next = {rx_byte, 8'h00};
                phase_next   = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                exp_crc_next = exp_full;
                crc_next     = CRC_INIT;
                left_next    = length_reg;
                if (length_reg == 16'd0) begin
                    // Empty payload: end the frame here
                    result.has_result = 1'b1;
                    result.frame_end  = 1'b1;
                    result.crc_ok     = (exp_full == CRC_INIT);
                    phase_next        = PH_HUNT;
                    run_next          = '0;
                end else begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                crc_next            = crc_upd;
                left_next           = left_dec;
                result.has_result   = 1'b1;
                result.payload_byte = rx_byte;
                result.byte_valid   = 1'b1;
                if (left_dec == 16'd0) begin
                    result.frame_end = 1'b1;
                    result.crc_ok    = (exp_crc_reg == crc_upd);
                    phase_next       = PH_HUNT;
                    run_next         = '0;
                end
            end
            default: begin
                phase_next = PH_HUNT;
                run_next   = '0;
            end
        endcase
    end

    // Advance the parse state once per processed byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            run_reg     <= '0;
            topic_reg   <= '0;
            length_reg  <= '0;
            left_reg    <= '0;
            exp_crc_reg <= '0;
            crc_reg     <= CRC_INIT;
        end else if (step) begin
            phase_reg   <= phase_next;
            run_reg     <= run_next;
            topic_reg   <= topic_next;
            length_reg  <= length_next;
            left_reg    <= left_next;
            exp_crc_reg <= exp_crc_next;
            crc_reg     <= crc_next;
        end
    end

endmodule

[rtl/sync_length_crc16_frame_deframer_unit.sv]
// Top level of the sync/length/CRC-16 frame deframer: input register, parser, result register.
// Path: an accepted byte waits in the input register until the parser can process it;
// any result it produces is then written to the result register and offered on the m_ side.
// Throughput: one byte per cycle while the result register is free or draining; the byte-wide
// CRC update and parse decode sit in one combinational pass between input and result register.
// Reset (synchronous, active low): hunting for sync, CRC at 0xFFFF, sync byte 62, both
// registers empty.
module sync_length_crc16_frame_deframer_unit
    import dfr_pkg::*;
#(
    parameter int SYNC_COUNT = SYNC_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    // byte request in
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    // result request out
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_payload_byte,
    output logic        m_byte_valid,
    output logic        m_frame_end,
    output logic        m_crc_ok,
    output logic [7:0]  m_topic,
    output logic [15:0] m_frame_len
);

    logic [7:0] sync_byte_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    res;
    logic       out_free;
    logic       step;

    // Hold the sync byte register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_byte_reg <= SYNC_BYTE_RST;
        end else if (cfg_we) begin
            sync_byte_reg <= cfg_wdata;
        end
    end

    dfr_parser #(
        .SYNC_COUNT(SYNC_COUNT)
    ) u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .rx_byte  (in_byte_reg),
        .sync_byte(sync_byte_reg),
        .result   (res)
    );

    // Process the held byte when its result, if any, has a free slot
    assign out_free = !out_valid_reg || m_ready;
    assign step     = in_valid_reg && (!res.has_result || out_free);
    assign s_ready  = !in_valid_reg || step;

    // Capture the incoming request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // Load or drain the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= step && res.has_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && step && res.has_result) begin
            out_reg <= res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_payload_byte = out_reg.payload_byte;
    assign m_byte_valid   = out_reg.byte_valid;
    assign m_frame_end    = out_reg.frame_end;
    assign m_crc_ok       = out_reg.crc_ok;
    assign m_topic        = out_reg.topic;
    assign m_frame_len    = out_reg.frame_len;

endmodule
